// ===== sv/mcpf_pkg.sv =====
// ---------------------------------------------------------------------------
// mcpf_pkg
// Shared types, codes and constants of the motor command packet framer.
// ---------------------------------------------------------------------------
package mcpf_pkg;

	typedef enum logic [2:0] {
		OP_SPIN     = 3'd0,
		OP_SPEED    = 3'd1,
		OP_PID      = 3'd2,
		OP_RESET    = 3'd3,
		OP_RD_ENC   = 3'd4,
		OP_RD_SPEED = 3'd5,
		OP_REPLY    = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_ENC   = 2'd1,
		PEND_SPEED = 2'd2
	} pend_t;

	localparam logic KIND_TX   = 1'b0;
	localparam logic KIND_READ = 1'b1;

	localparam logic [1:0] WHEEL_NONE = 2'd3;

	localparam logic [7:0] ADDR_BASE      = 8'd128;
	localparam logic [7:0] CMD_SPEED      = 8'd35;
	localparam logic [7:0] CMD_PID        = 8'd28;
	localparam logic [7:0] CMD_RESET      = 8'd20;
	localparam logic [7:0] CMD_RD_ENC     = 8'd16;
	localparam logic [7:0] CMD_RD_SPEED   = 8'd18;
	localparam logic [31:0] SPIN_MAX      = 32'd127;

	localparam int PKT_BYTES   = 18;   // longest packet body, checksum excluded
	localparam int REPLY_WORD  = 4;    // value bytes in a reply
	localparam int REPLY_SUMAT = 5;    // position of the reply checksum byte
	localparam int QDEPTH_DEFAULT = 2;

	typedef struct packed {
		op_t                op;
		logic [1:0]         wheel;
		logic signed [31:0] value;
		logic [31:0]        pid_d;
		logic [31:0]        pid_p;
		logic [31:0]        pid_i;
		logic [31:0]        pid_q;
		logic [7:0]         rx_byte;
	} in_t;

	typedef struct packed {
		logic               kind;
		logic [7:0]         tx_byte;
		logic               tx_last;
		logic [1:0]         read_wheel;
		logic signed [31:0] read_value;
		logic               read_bad;
	} out_t;

	// one queued job: either a packet to send or a finished read result
	typedef struct packed {
		logic                           is_read;
		logic [4:0]                     len;
		logic                           with_sum;
		logic [PKT_BYTES-1:0][7:0]      bytes;
		logic [1:0]                     rd_wheel;
		logic [31:0]                    rd_value;
		logic                           rd_bad;
	} job_t;

	function automatic logic [7:0] wheel_addr(input logic [1:0] w);
		logic [7:0] a;
		a = (w == 2'd1) ? 8'd129 : 8'd128;
		return a;
	endfunction

	function automatic logic [7:0] wheel_chan(input logic [1:0] w);
		logic [7:0] c;
		c = (w == 2'd2) ? 8'd0 : 8'd1;
		return c;
	endfunction

endpackage

// ===== sv/mcpf_queue.sv =====
// ---------------------------------------------------------------------------
// mcpf_queue
// Short job queue between the classifier and the byte sequencer.
// ---------------------------------------------------------------------------
module mcpf_queue import mcpf_pkg::*; #(
	parameter int DEPTH = QDEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/mcpf_front.sv =====
// ---------------------------------------------------------------------------
// mcpf_front
// Classifies commands into packet jobs and collects reply bytes.
// ---------------------------------------------------------------------------
module mcpf_front import mcpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  in_t  in_data,
	output logic push,
	output job_t push_job
);

	pend_t       pend_q, pend_d;
	logic [1:0]  pwheel_q, pwheel_d;
	logic [2:0]  count_q, count_d;
	logic [6:0]  sum_q, sum_d;
	logic [31:0] word_q, word_d;
	logic [31:0] last_enc_q [3];

	logic        enc_we;
	logic [1:0]  enc_idx;
	logic [31:0] enc_val;

	logic [7:0]  addr;
	logic [7:0]  chan;
	logic [7:0]  cmd;
	logic [31:0] val_u;
	logic [31:0] mag;
	logic [31:0] spd;
	logic        bad;
	logic [31:0] res;

	// byte slot [n] goes out before [n+1], so the top byte lands in the lowest slot
	function automatic logic [31:0] be_word(input logic [31:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

	always_comb begin
		push_job = '0;
		push     = 1'b0;
		pend_d   = pend_q;
		pwheel_d = pwheel_q;
		count_d  = count_q;
		sum_d    = sum_q;
		word_d   = word_q;
		enc_we   = 1'b0;
		enc_idx  = pwheel_q;
		enc_val  = word_q;
		addr     = wheel_addr(in_data.wheel);
		chan     = wheel_chan(in_data.wheel);
		cmd      = '0;
		val_u    = in_data.value;
		mag      = val_u[31] ? (32'd0 - val_u) : val_u;
		if (mag > SPIN_MAX) begin
			mag = SPIN_MAX;
		end
		spd      = (val_u == '0) ? 32'd1 : val_u;
		bad      = 1'b0;
		res      = word_q;

		if (accept) begin
			unique case (in_data.op)
				OP_RESET: begin
					push              = 1'b1;
					push_job.len      = 5'd2;
					push_job.with_sum = 1'b1;
					push_job.bytes[0] = ADDR_BASE + {6'b0, in_data.wheel};
					push_job.bytes[1] = CMD_RESET;
				end
				OP_REPLY: begin
					if (pend_q != PEND_NONE) begin
						if (count_q < 3'(REPLY_WORD)) begin
							word_d = {word_q[23:0], in_data.rx_byte};
						end
						if (count_q < 3'(REPLY_SUMAT)) begin
							sum_d   = sum_q + in_data.rx_byte[6:0];
							count_d = count_q + 3'd1;
						end else begin
							bad = (in_data.rx_byte != {1'b0, sum_q});
							if (pend_q == PEND_ENC && pwheel_q != WHEEL_NONE) begin
								if (bad) begin
									res = last_enc_q[pwheel_q];
								end else begin
									enc_we = 1'b1;
								end
							end
							push              = 1'b1;
							push_job.is_read  = 1'b1;
							push_job.rd_wheel = pwheel_q;
							push_job.rd_value = res;
							push_job.rd_bad   = bad;
							pend_d  = PEND_NONE;
							count_d = '0;
							sum_d   = '0;
							word_d  = '0;
						end
					end
				end
				OP_SPIN, OP_SPEED, OP_PID, OP_RD_ENC, OP_RD_SPEED: begin
					if (in_data.wheel != WHEEL_NONE) begin
						push              = 1'b1;
						push_job.bytes[0] = addr;
						if (in_data.op == OP_SPIN) begin
							push_job.len      = 5'd3;
							push_job.with_sum = 1'b1;
							push_job.bytes[1] = {chan[5:0], 1'b0, val_u[31]};
							push_job.bytes[2] = mag[7:0];
						end else if (in_data.op == OP_SPEED) begin
							push_job.len      = 5'd6;
							push_job.with_sum = 1'b1;
							push_job.bytes[1] = CMD_SPEED + chan;
							push_job.bytes[5:2] = be_word(spd);
						end else if (in_data.op == OP_PID) begin
							push_job.len        = 5'd18;
							push_job.with_sum   = 1'b1;
							push_job.bytes[1]   = CMD_PID + chan;
							push_job.bytes[5:2]   = be_word(in_data.pid_d);
							push_job.bytes[9:6]   = be_word(in_data.pid_p);
							push_job.bytes[13:10] = be_word(in_data.pid_i);
							push_job.bytes[17:14] = be_word(in_data.pid_q);
						end else begin
							cmd = ((in_data.op == OP_RD_ENC) ? CMD_RD_ENC : CMD_RD_SPEED) + chan;
							push_job.len      = 5'd2;
							push_job.bytes[1] = cmd;
							pend_d   = (in_data.op == OP_RD_ENC) ? PEND_ENC : PEND_SPEED;
							pwheel_d = in_data.wheel;
							count_d  = '0;
							word_d   = '0;
							sum_d    = addr[6:0] + cmd[6:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q        <= PEND_NONE;
			pwheel_q      <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			word_q        <= '0;
			last_enc_q[0] <= '0;
			last_enc_q[1] <= '0;
			last_enc_q[2] <= '0;
		end else begin
			pend_q   <= pend_d;
			pwheel_q <= pwheel_d;
			count_q  <= count_d;
			sum_q    <= sum_d;
			word_q   <= word_d;
			if (enc_we) begin
				last_enc_q[enc_idx] <= enc_val;
			end
		end
	end

endmodule

// ===== sv/mcpf_back.sv =====
// ---------------------------------------------------------------------------
// mcpf_back
// Walks the head job one beat per unstalled cycle, plus any 7-bit checksum.
// ---------------------------------------------------------------------------
module mcpf_back import mcpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  job_t head_job,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic [4:0] idx_q;
	logic [6:0] acc_q;
	logic       out_valid_q;
	out_t       out_q;

	logic       advance;
	logic       last;
	out_t       beat;

	assign advance   = head_valid && (!out_valid_q || out_ready);
	assign pop       = advance && last;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		beat = '0;
		last = 1'b0;
		if (head_job.is_read) begin
			beat.kind       = KIND_READ;
			beat.read_wheel = head_job.rd_wheel;
			beat.read_value = head_job.rd_value;
			beat.read_bad   = head_job.rd_bad;
			last            = 1'b1;
		end else if (idx_q < head_job.len) begin
			beat.kind    = KIND_TX;
			beat.tx_byte = head_job.bytes[idx_q];
			last         = (idx_q == head_job.len - 5'd1) && !head_job.with_sum;
			beat.tx_last = last;
		end else begin
			// checksum beat
			beat.kind    = KIND_TX;
			beat.tx_byte = {1'b0, acc_q};
			beat.tx_last = 1'b1;
			last         = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				if (last) begin
					idx_q <= '0;
					acc_q <= '0;
				end else begin
					idx_q <= idx_q + 5'd1;
					acc_q <= acc_q + beat.tx_byte[6:0];
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/motor_command_packet_framer.sv =====
// ---------------------------------------------------------------------------
// motor_command_packet_framer
// Frames motor-controller command packets and checks read replies.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one command or reply byte
// per beat. Output channel (out_valid/out_ready/out_data) gives one beat per
// packet byte (kind 0) or one beat per completed read (kind 1).
// The front classifies an item in the cycle it is accepted and drops a job
// into a QUEUE_DEPTH-entry queue; the back sends the head job one beat per
// cycle while the receiver keeps up. A packet's first beat passes through
// the queue entry, then the output register. A packet takes one beat per
// byte (2 to 19 bytes); a read result is a single beat. Commands are taken
// back to back while the queue has room; in_ready drops only when the queue
// is full. Items that make no beats (unknown op, wheel three on a command
// other than a reset, stray reply byte) are still taken one per cycle while
// there is room. Reset clears the pending read, the reply collector, the
// stored encoder counts and the queue. A stalled receiver holds the output
// register; the queue then fills and stalls the sender, with no beat lost.
// ---------------------------------------------------------------------------
module motor_command_packet_framer import mcpf_pkg::*; #(
	parameter int QUEUE_DEPTH = QDEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic accept;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	logic head_valid;
	job_t head_job;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	mcpf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_data  (in_data),
		.push     (push),
		.push_job (push_job)
	);

	mcpf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	mcpf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor command packet framer. Command and reply
// items go in through a valid/ready sender; an in-bench copy of the framing
// and reply-checking rules predicts every output beat, and each accepted beat
// is compared field by field with the oldest prediction. Directed items cover
// clamping, zero speed, long PID packets, resets, ignored items and reply
// corner cases. Random traffic, with a read on 45 of 100 picks, then runs
// under three sender/receiver idling mixes.
// ---------------------------------------------------------------------------
module testbench;
	import mcpf_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPLY_BYTES  = 6;

	localparam logic [2:0] OP_UNUSED = 3'd7;

	// indexed by wheel: [0] wheel 0 ... [2] wheel 2
	localparam logic [2:0][7:0] WHEEL_ADDR = {8'd128, 8'd129, 8'd128};
	localparam logic [2:0][7:0] WHEEL_CHAN = {8'd0, 8'd1, 8'd1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;
	int cycle_count = 0;
	int items_taken = 0;
	int beats_checked = 0;
	int reads_checked = 0;

	// mirror of the framer's reply collector and encoder history
	pend_t            rd_pend = PEND_NONE;
	logic [1:0]       rd_wheel = '0;
	logic [2:0]       rd_count = '0;
	logic [6:0]       rd_sum = '0;
	logic [31:0]      rd_word = '0;
	logic [2:0][31:0] enc_last = '0;

	logic [18:0][7:0] pkt_buf;
	out_t             expected_beats[$];

	motor_command_packet_framer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("motor_command_packet_framer: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : beat_check
		out_t due;
		if (arst_n && out_valid && out_ready) begin
			if (expected_beats.size() == 0) begin
				$error("beat with nothing expected: kind %0d byte 0x%0h", out_data.kind,
					out_data.tx_byte);
				error_count++;
			end else begin
				due = expected_beats[0];
				expected_beats.delete(0);
				check_field("kind", 32'(due.kind), 32'(out_data.kind));
				check_field("tx_byte", 32'(due.tx_byte), 32'(out_data.tx_byte));
				check_field("tx_last", 32'(due.tx_last), 32'(out_data.tx_last));
				check_field("read_wheel", 32'(due.read_wheel), 32'(out_data.read_wheel));
				check_field("read_value", due.read_value, out_data.read_value);
				check_field("read_bad", 32'(due.read_bad), 32'(out_data.read_bad));
				beats_checked++;
				if (due.kind == KIND_READ)
					reads_checked++;
			end
		end
	end

	// queue the first len bytes of pkt_buf as transmit beats, checksum appended on request
	task automatic queue_packet(input int len, input bit with_sum);
		int k;
		int total;
		int sum;
		out_t b;
		sum = 0;
		for (k = 0; k < len; k++)
			sum += pkt_buf[k];
		if (with_sum)
			pkt_buf[len] = 8'(sum & 'h7f);
		total = with_sum ? len + 1 : len;
		for (k = 0; k < total; k++) begin
			b = '0;
			b.kind = KIND_TX;
			b.tx_byte = pkt_buf[k];
			b.tx_last = (k == total - 1);
			expected_beats.insert(expected_beats.size(), b);
		end
	endtask

	task automatic put_word(input int pos, input logic [31:0] w);
		pkt_buf[pos]     = w[31:24];
		pkt_buf[pos + 1] = w[23:16];
		pkt_buf[pos + 2] = w[15:8];
		pkt_buf[pos + 3] = w[7:0];
	endtask

	task automatic frame_item(input in_t it);
		logic [7:0]  chan;
		logic [7:0]  cmd;
		logic [31:0] mag;
		logic [31:0] spd;
		logic        neg;
		logic        bad;
		out_t        r;
		if (it.op == OP_RESET) begin
			items_taken++;
			pkt_buf[0] = ADDR_BASE + {6'b0, it.wheel};
			pkt_buf[1] = CMD_RESET;
			queue_packet(2, 1'b1);
		end else if (it.op == OP_REPLY) begin
			if (rd_pend != PEND_NONE) begin
				items_taken++;
				if (rd_count < REPLY_WORD)
					rd_word = {rd_word[23:0], it.rx_byte};
				if (rd_count < REPLY_SUMAT) begin
					rd_sum = rd_sum + it.rx_byte[6:0];
					rd_count++;
				end else begin
					// checksum byte compared as a full byte against the 7-bit sum
					bad = (it.rx_byte != {1'b0, rd_sum});
					r = '0;
					r.kind = KIND_READ;
					r.read_wheel = rd_wheel;
					r.read_value = rd_word;
					r.read_bad = bad;
					if (rd_pend == PEND_ENC) begin
						if (bad)
							r.read_value = enc_last[rd_wheel];
						else
							enc_last[rd_wheel] = rd_word;
					end
					expected_beats.insert(expected_beats.size(), r);
					rd_pend = PEND_NONE;
					rd_count = '0;
					rd_sum = '0;
					rd_word = '0;
				end
			end
		end else if (it.op != OP_UNUSED && it.wheel != WHEEL_NONE) begin
			items_taken++;
			chan = WHEEL_CHAN[it.wheel];
			pkt_buf[0] = WHEEL_ADDR[it.wheel];
			case (it.op)
			OP_SPIN: begin
				neg = it.value[31];
				mag = neg ? 32'd0 - it.value : it.value;
				if (mag > SPIN_MAX)
					mag = SPIN_MAX;
				pkt_buf[1] = {chan[5:0], 1'b0, neg};
				pkt_buf[2] = mag[7:0];
				queue_packet(3, 1'b1);
			end
			OP_SPEED: begin
				spd = (it.value == 0) ? 32'd1 : it.value;
				pkt_buf[1] = CMD_SPEED + chan;
				put_word(2, spd);
				queue_packet(6, 1'b1);
			end
			OP_PID: begin
				pkt_buf[1] = CMD_PID + chan;
				put_word(2, it.pid_d);
				put_word(6, it.pid_p);
				put_word(10, it.pid_i);
				put_word(14, it.pid_q);
				queue_packet(18, 1'b1);
			end
			OP_RD_ENC, OP_RD_SPEED: begin
				cmd = ((it.op == OP_RD_ENC) ? CMD_RD_ENC : CMD_RD_SPEED) + chan;
				pkt_buf[1] = cmd;
				// a new read always restarts the collector
				rd_pend = (it.op == OP_RD_ENC) ? PEND_ENC : PEND_SPEED;
				rd_wheel = it.wheel;
				rd_count = '0;
				rd_word = '0;
				rd_sum = pkt_buf[0][6:0] + cmd[6:0];
				queue_packet(2, 1'b0);
			end
			default: ;
			endcase
		end
	endtask

	function automatic in_t build_item(input logic [2:0] op, input logic [1:0] wheel,
			input logic [31:0] value);
		in_t it;
		it.op = op_t'(op);
		it.wheel = wheel;
		it.value = value;
		it.pid_d = $urandom();
		it.pid_p = $urandom();
		it.pid_i = $urandom();
		it.pid_q = $urandom();
		it.rx_byte = 8'($urandom());
		return it;
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		case ($urandom_range(0, 5))
		0: v = $urandom_range(0, 300) - 150;
		1: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
		2: v = $urandom_range(0, 1) ? 32'd128 : 32'hffff_ff80;
		3: v = 32'd0;
		default: v = $urandom();
		endcase
		return v;
	endfunction

	// valid stays high after a beat; the next call either idles or replaces the payload
	task automatic send_item(input in_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		frame_item(it);
	endtask

	// reply bytes continue from wherever the collector stands
	task automatic send_reply_bytes(input logic [31:0] word, input logic [7:0] status,
			input int count, input bit corrupt);
		in_t        it;
		int         idx;
		logic [7:0] b;
		logic [7:0] flip;
		repeat (count) begin
			idx = rd_count;
			flip = corrupt ? 8'($urandom_range(1, 255)) : 8'd0;
			if (idx < REPLY_WORD)
				b = 8'(word >> (8 * (3 - idx)));
			else if (idx < REPLY_SUMAT)
				b = status;
			else
				b = {1'b0, rd_sum} ^ flip;
			it = build_item(OP_REPLY, 2'($urandom_range(0, 3)), $urandom());
			it.rx_byte = b;
			send_item(it);
		end
	endtask

	task automatic test_spin_limits();
		send_item(build_item(OP_SPIN, 2'd0, 32'h8000_0000));
		send_item(build_item(OP_SPIN, 2'd2, 32'h7fff_ffff));
		send_item(build_item(OP_SPIN, 2'd1, 32'hffff_fffb));
		send_item(build_item(OP_SPIN, 2'd0, 32'd0));
	endtask

	task automatic test_speed_limits();
		send_item(build_item(OP_SPEED, 2'd1, 32'd0));
		send_item(build_item(OP_SPEED, 2'd2, 32'h8000_0000));
	endtask

	task automatic test_set_pid();
		in_t it;
		it = build_item(OP_PID, 2'd0, pick_value());
		it.pid_d = 32'hffff_ffff;
		it.pid_p = 32'h0;
		it.pid_i = 32'h0123_4567;
		it.pid_q = 32'hfedc_ba98;
		send_item(it);
	endtask

	task automatic test_reset_encoders();
		send_item(build_item(OP_RESET, WHEEL_NONE, pick_value()));
	endtask

	task automatic test_ignored_items();
		send_item(build_item(OP_RD_ENC, WHEEL_NONE, pick_value()));
		send_item(build_item(OP_UNUSED, 2'd1, pick_value()));
		send_reply_bytes(32'h0, 8'hff, 1, 1'b0);
	endtask

	task automatic test_encoder_reads();
		// good read with a spin slipped in mid-reply
		send_item(build_item(OP_RD_ENC, 2'd2, pick_value()));
		send_reply_bytes(32'h8000_0001, 8'h00, 2, 1'b0);
		send_item(build_item(OP_SPIN, 2'd1, 32'd77));
		send_reply_bytes(32'h8000_0001, 8'h00, REPLY_BYTES - 2, 1'b0);
		// restarted read ending in a bad checksum falls back to the stored count
		send_item(build_item(OP_RD_ENC, 2'd2, pick_value()));
		send_reply_bytes(32'h1234_5678, 8'hff, 3, 1'b0);
		send_item(build_item(OP_RD_ENC, 2'd2, pick_value()));
		send_reply_bytes(32'h0bad_f00d, 8'h5a, REPLY_BYTES, 1'b1);
	endtask

	task automatic test_random_traffic(input int quota);
		int          target;
		int          pick;
		int          split;
		logic [2:0]  op;
		logic [1:0]  wheel;
		logic [31:0] word;
		logic [7:0]  status;
		target = items_taken + quota;
		while (items_taken < target) begin
			pick = $urandom_range(0, 99);
			word = pick_value();
			status = 8'($urandom());
			if (pick < 45) begin
				op = $urandom_range(0, 1) ? OP_RD_ENC : OP_RD_SPEED;
				send_item(build_item(op, 2'($urandom_range(0, 2)), pick_value()));
				split = $urandom_range(0, 9);
				if (split == 0) begin
					// reply stops short; a later read restarts collection
					send_reply_bytes(word, status, $urandom_range(0, 5), 1'b0);
				end else if (split == 1) begin
					split = $urandom_range(1, 5);
					send_reply_bytes(word, status, split, 1'b0);
					send_item(build_item(3'($urandom_range(0, 3)), 2'($urandom_range(0, 2)),
						pick_value()));
					send_reply_bytes(word, status, REPLY_BYTES - split,
						$urandom_range(0, 3) == 0);
				end else begin
					send_reply_bytes(word, status, REPLY_BYTES, $urandom_range(0, 3) == 0);
				end
			end else if (pick < 85) begin
				op = 3'($urandom_range(0, 3));
				wheel = 2'((op == OP_RESET) ? $urandom_range(0, 3) : $urandom_range(0, 2));
				send_item(build_item(op, wheel, pick_value()));
			end else begin
				case ($urandom_range(0, 2))
				0: begin
					op = 3'($urandom_range(0, 4));
					if (op == OP_RESET)
						op = OP_RD_SPEED;
					send_item(build_item(op, WHEEL_NONE, pick_value()));
				end
				1: send_item(build_item(OP_UNUSED, 2'($urandom_range(0, 3)), pick_value()));
				default: send_reply_bytes(word, status, 1, 1'b0);
				endcase
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 27;
		recv_idle_pct = 49;
		test_spin_limits();
		test_speed_limits();
		test_set_pid();
		test_reset_encoders();
		test_ignored_items();
		test_encoder_reads();
		test_random_traffic(130);

		send_idle_pct = 49;
		recv_idle_pct = 27;
		test_random_traffic(130);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(130);

		in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d effective items sent over three idling mixes (directed then random)",
			items_taken);
		$display("%0d beats checked, %0d of them read results", beats_checked, reads_checked);
		if (error_count == 0)
			$display("motor_command_packet_framer: match");
		else
			$display("motor_command_packet_framer: mismatch");
		$finish;
	end

endmodule
